// ===== rtl/bba_pkg.sv =====
// shared types, codes and helpers of the bitmap block allocator
// used by the allocator core and the divider; no dependencies

package bba_pkg;

    localparam int DATA_W       = 32;
    localparam int SPB_W        = 8;
    localparam int BCNT_W       = 13;
    localparam int CFG_ADDR_W   = 2;
    localparam int STATUS_W     = 2;
    localparam int IN_TDATA_W   = 32;
    localparam int OUT_TDATA_W  = 40;
    localparam int DIV_CNT_W    = $clog2(DATA_W);

    localparam logic [7:0] FULL_BYTE = 8'd255;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

    localparam logic FN_ALLOC = 1'b0;
    localparam logic FN_FREE  = 1'b1;

    localparam logic [CFG_ADDR_W-1:0] CFG_SPB   = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_FIRST = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_COUNT = 2'd2;

    localparam logic [SPB_W-1:0]  SPB_RST   = 8'd1;
    localparam logic [DATA_W-1:0] FIRST_RST = 32'd0;
    localparam logic [BCNT_W-1:0] COUNT_RST = 13'd4096;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_MUL,
        S_GRANT,
        S_DIV_START,
        S_DIV_WAIT,
        S_FREE_WR,
        S_DONE
    } t_state;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

    // position of the lowest zero bit, bit 0 first
    function automatic logic [2:0] lowest_clear(input logic [7:0] b);
        logic [2:0] pos;
        pos = 3'd0;
        for (int i = 7; i >= 0; i--) begin
            if (!b[i]) begin
                pos = 3'(i);
            end
        end
        return pos;
    endfunction

endpackage

// ===== rtl/bitmap_block_allocator_core.sv =====
// Bitmap block allocator: a request enters on the s side (tuser = func, tdata = sector
// address) and one result leaves on the m side. After reset the bitmap memory is swept
// to zero, one byte per cycle, over all (MAX_BLOCKS+7)/8 bytes (512 by default) while
// s_tready stays low; configuration writes are taken throughout. An allocate request
// scans the bitmap through the single read port of the bitmap memory, one byte per cycle,
// until it finds a byte with a clear bit or reaches the end of the map. A free request
// is worked out by the shift-subtract divider, 32 steps. One request is worked on at a
// time; the result sits in an output register so a new request can be taken while it
// waits.
// depends on bba_pkg, bba_bitmap_ram and bba_divider

module bitmap_block_allocator_core #(
    parameter int MAX_BLOCKS = 4096
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // configuration write port
    input  logic                             i_cfg_we,
    input  logic [bba_pkg::CFG_ADDR_W-1:0]   i_cfg_addr,
    input  logic [bba_pkg::DATA_W-1:0]       i_cfg_data,
    // request stream
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    input  logic [bba_pkg::IN_TDATA_W-1:0]   i_s_tdata,   // [31:0] sector_address
    input  logic                             i_s_tuser,   // [0] func
    // result stream
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    output logic [bba_pkg::OUT_TDATA_W-1:0]  o_m_tdata    // [1:0] status, [33:2] granted_sector
);

    localparam int MAP_BYTES = (MAX_BLOCKS + 7) / 8;
    localparam int ADDR_W    = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;
    localparam int SCAN_W    = $clog2(MAP_BYTES + 1);
    localparam int IDX_W     = ADDR_W + 3;
    localparam int PROD_W    = IDX_W + bba_pkg::SPB_W;
    localparam logic [bba_pkg::DATA_W-1:0] MAX_CNT = bba_pkg::DATA_W'(MAX_BLOCKS);
    localparam logic [SCAN_W-1:0] SCAN_END  = SCAN_W'(MAP_BYTES);
    localparam logic [SCAN_W-1:0] CLEAR_END = SCAN_W'(MAP_BYTES - 1);

    // configuration
    logic [bba_pkg::SPB_W-1:0]  r_spb;
    logic [bba_pkg::DATA_W-1:0] r_first;
    logic [bba_pkg::BCNT_W-1:0] r_bcnt;

    // sequencer and datapath
    bba_pkg::t_state r_state, n_state;
    logic [SCAN_W-1:0]            r_scan, n_scan;
    logic                         r_rd_vld, n_rd_vld;
    logic [ADDR_W-1:0]            r_rd_addr, n_rd_addr;
    logic                         r_func, n_func;
    logic [bba_pkg::DATA_W-1:0]   r_addr, n_addr;
    logic [IDX_W-1:0]             r_idx, n_idx;
    logic [PROD_W-1:0]            r_prod, n_prod;
    logic [bba_pkg::STATUS_W-1:0] r_status, n_status;
    logic [bba_pkg::DATA_W-1:0]   r_granted, n_granted;
    logic                         r_out_vld, n_out_vld;
    logic [bba_pkg::STATUS_W-1:0] r_out_status, n_out_status;
    logic [bba_pkg::DATA_W-1:0]   r_out_granted, n_out_granted;

    logic                         ram_we;
    logic [ADDR_W-1:0]            ram_waddr;
    logic [7:0]                   ram_wdata;
    logic [ADDR_W-1:0]            ram_raddr;
    logic [7:0]                   ram_rdata;

    logic                         div_start;
    logic [bba_pkg::DATA_W-1:0]   div_quo;
    bba_pkg::t_div_stat           div_stat;

    logic [bba_pkg::SPB_W-1:0]    spb_eff;
    logic [bba_pkg::DATA_W-1:0]   bcnt_ext;
    logic [bba_pkg::DATA_W-1:0]   cnt_eff;
    logic                         s_accept;
    logic                         found;
    logic                         scan_done;
    logic [2:0]                   free_bit;
    logic [IDX_W-1:0]             scan_idx;
    logic                         scan_in_range;
    logic                         free_in_range;
    logic                         out_load;

    assign spb_eff  = (r_spb == '0) ? bba_pkg::SPB_W'(1) : r_spb;
    assign bcnt_ext = bba_pkg::DATA_W'(r_bcnt);
    assign cnt_eff  = (bcnt_ext > MAX_CNT) ? MAX_CNT : bcnt_ext;

    assign o_s_tready = (r_state == bba_pkg::S_IDLE);
    assign s_accept   = i_s_tvalid && o_s_tready;

    assign found         = r_rd_vld && (ram_rdata != bba_pkg::FULL_BYTE);
    assign scan_done     = !r_rd_vld && (r_scan == SCAN_END);
    assign free_bit      = bba_pkg::lowest_clear(ram_rdata);
    assign scan_idx      = {r_rd_addr, free_bit};
    assign scan_in_range = (bba_pkg::DATA_W'(scan_idx) < cnt_eff);
    assign free_in_range = (div_quo < cnt_eff);
    assign out_load      = (r_state == bba_pkg::S_DONE) && (!r_out_vld || i_m_tready);

    bba_bitmap_ram #(
        .DEPTH  (MAP_BYTES),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    bba_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_addr - r_first),
        .i_divisor  (spb_eff),
        .o_quotient (div_quo),
        .o_stat     (div_stat)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            bba_pkg::S_CLEAR: begin
                if (r_scan == CLEAR_END) begin
                    n_state = bba_pkg::S_IDLE;
                end
            end
            bba_pkg::S_IDLE: begin
                if (s_accept) begin
                    n_state = (i_s_tuser == bba_pkg::FN_FREE) ? bba_pkg::S_DIV_START
                                                              : bba_pkg::S_SCAN;
                end
            end
            bba_pkg::S_SCAN: begin
                if (found) begin
                    n_state = scan_in_range ? bba_pkg::S_MUL : bba_pkg::S_DONE;
                end else if (scan_done) begin
                    n_state = bba_pkg::S_DONE;
                end
            end
            bba_pkg::S_MUL:       n_state = bba_pkg::S_GRANT;
            bba_pkg::S_GRANT:     n_state = bba_pkg::S_DONE;
            bba_pkg::S_DIV_START: n_state = bba_pkg::S_DIV_WAIT;
            bba_pkg::S_DIV_WAIT: begin
                if (div_stat.done) begin
                    n_state = free_in_range ? bba_pkg::S_FREE_WR : bba_pkg::S_DONE;
                end
            end
            bba_pkg::S_FREE_WR:   n_state = bba_pkg::S_DONE;
            bba_pkg::S_DONE: begin
                if (out_load) begin
                    n_state = bba_pkg::S_IDLE;
                end
            end
            default:              n_state = bba_pkg::S_IDLE;
        endcase
    end

    // datapath and memory controls
    always_comb begin
        n_scan        = r_scan;
        n_rd_vld      = 1'b0;
        n_rd_addr     = r_rd_addr;
        n_func        = r_func;
        n_addr        = r_addr;
        n_idx         = r_idx;
        n_prod        = r_prod;
        n_status      = r_status;
        n_granted     = r_granted;
        ram_we        = 1'b0;
        ram_waddr     = '0;
        ram_wdata     = '0;
        ram_raddr     = '0;
        div_start     = 1'b0;
        case (r_state)
            bba_pkg::S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_scan[ADDR_W-1:0];
                ram_wdata = '0;
                n_scan    = r_scan + 1'b1;
            end
            bba_pkg::S_IDLE: begin
                if (s_accept) begin
                    n_func = i_s_tuser;
                    n_addr = i_s_tdata;
                    n_scan = '0;
                end
            end
            bba_pkg::S_SCAN: begin
                // read of byte r_scan overlaps the check of byte r_rd_addr
                if (found) begin
                    n_status  = bba_pkg::ST_FULL;
                    n_granted = '0;
                    if (scan_in_range) begin
                        ram_we    = 1'b1;
                        ram_waddr = r_rd_addr;
                        ram_wdata = ram_rdata | (8'd1 << free_bit);
                        n_idx     = scan_idx;
                    end
                end else if (scan_done) begin
                    n_status  = bba_pkg::ST_FULL;
                    n_granted = '0;
                end else if (r_scan != SCAN_END) begin
                    ram_raddr = r_scan[ADDR_W-1:0];
                    n_rd_addr = r_scan[ADDR_W-1:0];
                    n_rd_vld  = 1'b1;
                    n_scan    = r_scan + 1'b1;
                end
            end
            bba_pkg::S_MUL: begin
                n_prod = PROD_W'(r_idx) * PROD_W'(spb_eff);
            end
            bba_pkg::S_GRANT: begin
                n_status  = bba_pkg::ST_OK;
                n_granted = r_first + bba_pkg::DATA_W'(r_prod);
            end
            bba_pkg::S_DIV_START: begin
                div_start = 1'b1;
            end
            bba_pkg::S_DIV_WAIT: begin
                ram_raddr = div_quo[IDX_W-1:3];
                if (div_stat.done) begin
                    n_idx     = div_quo[IDX_W-1:0];
                    n_status  = free_in_range ? bba_pkg::ST_OK : bba_pkg::ST_RANGE;
                    n_granted = '0;
                end
            end
            bba_pkg::S_FREE_WR: begin
                ram_we    = 1'b1;
                ram_waddr = r_idx[IDX_W-1:3];
                ram_wdata = ram_rdata & ~(8'd1 << r_idx[2:0]);
            end
            default: begin
            end
        endcase
    end

    // output register
    always_comb begin
        n_out_vld     = r_out_vld;
        n_out_status  = r_out_status;
        n_out_granted = r_out_granted;
        if (out_load) begin
            n_out_vld     = 1'b1;
            n_out_status  = r_status;
            n_out_granted = r_granted;
        end else if (i_m_tready) begin
            n_out_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= bba_pkg::S_CLEAR;
            r_scan    <= '0;
            r_rd_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_spb     <= bba_pkg::SPB_RST;
            r_first   <= bba_pkg::FIRST_RST;
            r_bcnt    <= bba_pkg::COUNT_RST;
        end else begin
            r_state   <= n_state;
            r_scan    <= n_scan;
            r_rd_vld  <= n_rd_vld;
            r_out_vld <= n_out_vld;
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    bba_pkg::CFG_SPB:   r_spb   <= i_cfg_data[bba_pkg::SPB_W-1:0];
                    bba_pkg::CFG_FIRST: r_first <= i_cfg_data;
                    bba_pkg::CFG_COUNT: r_bcnt  <= i_cfg_data[bba_pkg::BCNT_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
        r_rd_addr     <= n_rd_addr;
        r_func        <= n_func;
        r_addr        <= n_addr;
        r_idx         <= n_idx;
        r_prod        <= n_prod;
        r_status      <= n_status;
        r_granted     <= n_granted;
        r_out_status  <= n_out_status;
        r_out_granted <= n_out_granted;
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = {{(bba_pkg::OUT_TDATA_W - bba_pkg::DATA_W - bba_pkg::STATUS_W){1'b0}},
                         r_out_granted, r_out_status};

    // the bitmap is only written by the clearing pass or by a request in flight
    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == bba_pkg::S_IDLE || r_state == bba_pkg::S_DONE) |-> !ram_we)
        else $error("bitmap written outside a request");

    // a failed request never carries a sector
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out_status != bba_pkg::ST_OK) |-> (r_out_granted == '0))
        else $error("granted sector not zero on failure");

    // the divider finishes only while the sequencer waits for it
    a_div_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_stat.done |-> (r_state == bba_pkg::S_DIV_WAIT))
        else $error("divider finished outside the wait state");

    // a free request goes through the divider, an allocate through the scan
    a_path: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == bba_pkg::S_SCAN) |-> (r_func == bba_pkg::FN_ALLOC))
        else $error("free request entered the bitmap scan");

endmodule

// ===== rtl/bba_bitmap_ram.sv =====
// block bitmap storage: one write port, one read port with registered data
// uses bba_pkg for nothing but sits beside it in the allocator

module bba_bitmap_ram #(
    parameter int DEPTH  = 512,
    parameter int ADDR_W = 9
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [7:0]        i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [7:0]        o_rdata
);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/bba_divider.sv =====
// iterative restoring divider, one quotient bit per cycle
// depends on bba_pkg for widths and the status struct

module bba_divider (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [bba_pkg::DATA_W-1:0] i_dividend,
    input  logic [bba_pkg::SPB_W-1:0]  i_divisor,
    output logic [bba_pkg::DATA_W-1:0] o_quotient,
    output bba_pkg::t_div_stat         o_stat
);

    logic [bba_pkg::DATA_W-1:0]    r_quo, n_quo;
    logic [bba_pkg::SPB_W-1:0]     r_rem, n_rem;
    logic [bba_pkg::SPB_W-1:0]     r_div, n_div;
    logic [bba_pkg::DIV_CNT_W-1:0] r_cnt, n_cnt;
    logic                          r_busy, n_busy;
    logic                          r_done, n_done;

    logic [bba_pkg::SPB_W:0] trial;
    logic                    ge;

    assign trial = {r_rem, r_quo[bba_pkg::DATA_W-1]};
    assign ge    = (trial >= {1'b0, r_div});

    always_comb begin
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_div  = r_div;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_start) begin
            n_quo  = i_dividend;
            n_rem  = '0;
            n_div  = i_divisor;
            n_cnt  = '0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            // remainder stays below the divisor, so it fits in SPB_W bits
            n_rem = ge ? bba_pkg::SPB_W'(trial - {1'b0, r_div})
                       : trial[bba_pkg::SPB_W-1:0];
            n_quo = {r_quo[bba_pkg::DATA_W-2:0], ge};
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == bba_pkg::DIV_CNT_W'(bba_pkg::DATA_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_div <= n_div;
    end

    assign o_quotient  = r_quo;
    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;

endmodule
